@@ hw/rtl/stl_pkg.sv @@
// Shared beat types, token kind codes and character-class helpers for the lexer.
`default_nettype none

package stl_pkg;

   // token kind codes
   localparam logic [4:0] KIND_KEYWORD     = 5'd0;
   localparam logic [4:0] KIND_ARROW       = 5'd1;
   localparam logic [4:0] KIND_STRING      = 5'd2;
   localparam logic [4:0] KIND_IDENT       = 5'd3;
   localparam logic [4:0] KIND_INTEGER     = 5'd4;
   localparam logic [4:0] KIND_ASSIGN      = 5'd5;
   localparam logic [4:0] KIND_PLUS        = 5'd6;
   localparam logic [4:0] KIND_MINUS       = 5'd7;
   localparam logic [4:0] KIND_PERCENT     = 5'd8;
   localparam logic [4:0] KIND_STAR        = 5'd9;
   localparam logic [4:0] KIND_SLASH       = 5'd10;
   localparam logic [4:0] KIND_COLON       = 5'd11;
   localparam logic [4:0] KIND_COMMA       = 5'd12;
   localparam logic [4:0] KIND_LBRACE      = 5'd13;
   localparam logic [4:0] KIND_RBRACE      = 5'd14;
   localparam logic [4:0] KIND_LBRACKET    = 5'd15;
   localparam logic [4:0] KIND_RBRACKET    = 5'd16;
   localparam logic [4:0] KIND_LPAREN      = 5'd17;
   localparam logic [4:0] KIND_RPAREN      = 5'd18;
   localparam logic [4:0] KIND_LESS_EQ     = 5'd19;
   localparam logic [4:0] KIND_LESS        = 5'd20;
   localparam logic [4:0] KIND_GREATER_EQ  = 5'd21;
   localparam logic [4:0] KIND_GREATER     = 5'd22;
   localparam logic [4:0] KIND_UNKNOWN     = 5'd23;
   localparam logic [4:0] KIND_UNTERM      = 5'd24;

   // keyword spellings as packed byte strings
   localparam logic [47:0] WORD_IF     = 48'h0000_0000_6966;
   localparam logic [47:0] WORD_ELSE   = 48'h0000_656C_7365;
   localparam logic [47:0] WORD_RETURN = 48'h7265_7475_726E;

   // characters with a role of their own
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        last_of_item;
   } rsp_type;

   // up to two tokens from one input beat, packed toward first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } token_pair_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CHAR_UNDER);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39);
   endfunction

   // single-character operators and brackets; anything else is unknown
   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      k = KIND_UNKNOWN;
      unique case (c)
         8'h3D:   k = KIND_ASSIGN;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h25:   k = KIND_PERCENT;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h3A:   k = KIND_COLON;
         8'h2C:   k = KIND_COMMA;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h5B:   k = KIND_LBRACKET;
         8'h5D:   k = KIND_RBRACKET;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/source_token_lexer_unit.sv @@
// Top level of the streaming source lexer: scanner plus result queue.
//
//   channel | direction | beat     | carries
//   req     | in        | req_type | one source byte or end of text
//   rsp     | out       | rsp_type | one token: kind, start, length, last flag
//
// One source byte is taken per cycle while the queue has room; req_ready stays high
// while the four-entry token queue has room for two.
// A beat that closes a token and is itself a one-character token yields two rsp beats.
// A token is written into the queue when the byte that completes it is taken.
// Synchronous reset empties the queue and returns the scanner to idle at offset zero.
// Stalls on rsp fill the queue; req_ready drops once fewer than two entries are free.
`default_nettype none

module source_token_lexer_unit
   import stl_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_beat,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_beat
);

   // counters saturate at the smaller of the offset width and the field width
   localparam int CNT_BITS = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;

   token_pair_type tokens;
   logic           item_accept;
   logic           room;

   assign item_accept = req_valid && room;
   assign req_ready   = room;

   stl_scan #(
      .CNT_BITS (CNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (req_beat),
      .tokens      (tokens)
   );

   stl_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tokens),
      .pop       (rsp_valid && rsp_ready),
      .room      (room),
      .out_valid (rsp_valid),
      .out_beat  (rsp_beat)
   );

endmodule

`default_nettype wire

@@ hw/rtl/stl_scan.sv @@
// Scanner state and per-byte transition: closes the pending token and starts the next.
`default_nettype none

module stl_scan
   import stl_pkg::*;
#(
   parameter int CNT_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_accept,
   input  req_type        item,
   output token_pair_type tokens
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_STRING,
      MODE_MINUS,
      MODE_LESS,
      MODE_GREATER
   } mode_type;

   localparam logic [CNT_BITS-1:0] SAT = '1;
   localparam logic [CNT_BITS-1:0] ONE = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] TWO = CNT_BITS'(2);
   localparam logic [CNT_BITS-1:0] SIX = CNT_BITS'(6);

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
      return (v == SAT) ? v : v + ONE;
   endfunction

   mode_type            mode_ff, mode_in;
   logic [CNT_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0] pstart_ff, pstart_in;
   logic [CNT_BITS-1:0] plen_ff, plen_in;
   logic [47:0]         prefix_ff, prefix_in;

   logic                pend_emit;
   logic [4:0]          pend_kind;
   logic [CNT_BITS-1:0] pend_len;
   logic                start_emit;
   logic [4:0]          start_kind;
   logic                restart;
   logic [7:0]          c;
   logic                alnum;
   logic [4:0]          ident_kind;
   rsp_type             pend_tok, start_tok;

   assign c     = item.text_byte;
   assign alnum = is_alpha(c) || is_digit(c);

   // whole-word keyword match on the collected prefix
   always_comb begin
      ident_kind = KIND_IDENT;
      if ((plen_ff == TWO && prefix_ff == WORD_IF) ||
          (plen_ff == CNT_BITS'(4) && prefix_ff == WORD_ELSE) ||
          (plen_ff == SIX && prefix_ff == WORD_RETURN)) begin
         ident_kind = KIND_KEYWORD;
      end
   end

   // next state and emitted tokens for one beat
   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      pstart_in  = pstart_ff;
      plen_in    = plen_ff;
      prefix_in  = prefix_ff;
      pend_emit  = 1'b0;
      pend_kind  = KIND_IDENT;
      pend_len   = plen_ff;
      start_emit = 1'b0;
      start_kind = KIND_UNKNOWN;
      restart    = 1'b0;

      if (item.end_of_text) begin
         // flush whatever is pending
         pend_emit = (mode_ff != MODE_IDLE);
         unique case (mode_ff)
            MODE_IDENT:   pend_kind = ident_kind;
            MODE_INT:     pend_kind = KIND_INTEGER;
            MODE_STRING:  pend_kind = KIND_UNTERM;
            MODE_MINUS:   begin pend_kind = KIND_MINUS;   pend_len = ONE; end
            MODE_LESS:    begin pend_kind = KIND_LESS;    pend_len = ONE; end
            MODE_GREATER: begin pend_kind = KIND_GREATER; pend_len = ONE; end
            default:      pend_kind = KIND_IDENT;
         endcase
         mode_in   = MODE_IDLE;
         pstart_in = '0;
         plen_in   = '0;
         prefix_in = '0;
         pos_in    = '0;
      end else begin
         pos_in = sat_inc(pos_ff);
         unique case (mode_ff)
            MODE_IDENT: begin
               if (alnum) begin
                  if (plen_ff < SIX) prefix_in = {prefix_ff[39:0], c};
                  plen_in = sat_inc(plen_ff);
               end else begin
                  pend_emit = 1'b1;
                  pend_kind = ident_kind;
                  restart   = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  if (plen_ff < SIX) prefix_in = {prefix_ff[39:0], c};
                  plen_in = sat_inc(plen_ff);
               end else begin
                  pend_emit = 1'b1;
                  pend_kind = KIND_INTEGER;
                  restart   = 1'b1;
               end
            end
            MODE_STRING: begin
               plen_in = sat_inc(plen_ff);
               if (c == CHAR_QUOTE) begin
                  pend_emit = 1'b1;
                  pend_kind = KIND_STRING;
                  pend_len  = sat_inc(plen_ff);
                  mode_in   = MODE_IDLE;
                  pstart_in = '0;
                  plen_in   = '0;
                  prefix_in = '0;
               end
            end
            MODE_MINUS, MODE_LESS, MODE_GREATER: begin
               pend_emit = 1'b1;
               if (mode_ff == MODE_MINUS && c == CHAR_GREATER) begin
                  pend_kind = KIND_ARROW;
                  pend_len  = TWO;
               end else if (mode_ff == MODE_LESS && c == CHAR_EQUAL) begin
                  pend_kind = KIND_LESS_EQ;
                  pend_len  = TWO;
               end else if (mode_ff == MODE_GREATER && c == CHAR_EQUAL) begin
                  pend_kind = KIND_GREATER_EQ;
                  pend_len  = TWO;
               end else begin
                  pend_len = ONE;
                  restart  = 1'b1;
                  unique case (mode_ff)
                     MODE_MINUS: pend_kind = KIND_MINUS;
                     MODE_LESS:  pend_kind = KIND_LESS;
                     default:    pend_kind = KIND_GREATER;
                  endcase
               end
               mode_in   = MODE_IDLE;
               pstart_in = '0;
               plen_in   = '0;
               prefix_in = '0;
            end
            default: restart = 1'b1;
         endcase

         // start a new token from this byte
         if (restart) begin
            mode_in   = MODE_IDLE;
            pstart_in = '0;
            plen_in   = '0;
            prefix_in = '0;
            if (c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF) begin
               mode_in = MODE_IDLE;
            end else if (c == CHAR_QUOTE || is_alpha(c) || is_digit(c) ||
                         c == CHAR_MINUS || c == CHAR_LESS || c == CHAR_GREATER) begin
               pstart_in = pos_ff;
               plen_in   = ONE;
               if (c == CHAR_QUOTE) begin
                  mode_in = MODE_STRING;
               end else if (is_alpha(c)) begin
                  mode_in   = MODE_IDENT;
                  prefix_in = {40'd0, c};
               end else if (is_digit(c)) begin
                  mode_in = MODE_INT;
               end else if (c == CHAR_MINUS) begin
                  mode_in = MODE_MINUS;
               end else if (c == CHAR_LESS) begin
                  mode_in = MODE_LESS;
               end else begin
                  mode_in = MODE_GREATER;
               end
            end else begin
               start_emit = 1'b1;
               start_kind = single_kind(c);
            end
         end
      end
   end

   // pack tokens, first slot filled first
   always_comb begin
      pend_tok.token_kind    = pend_kind;
      pend_tok.token_start   = 16'(pstart_ff);
      pend_tok.token_length  = 16'(pend_len);
      pend_tok.last_of_item  = !start_emit;
      start_tok.token_kind   = start_kind;
      start_tok.token_start  = 16'(pos_ff);
      start_tok.token_length = 16'd1;
      start_tok.last_of_item = 1'b1;

      tokens.first  = pend_emit ? pend_tok : start_tok;
      tokens.second = start_tok;
      tokens.count  = item_accept ? (2'(pend_emit) + 2'(start_emit)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         prefix_ff <= '0;
      end else if (item_accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/stl_rsp_fifo.sv @@
// Four-entry token queue: takes up to two tokens a cycle, delivers one beat a cycle while pop is high.
`default_nettype none

module stl_rsp_fifo
   import stl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  token_pair_type push,
   input  logic           pop,
   output logic           room,
   output logic           out_valid,
   output rsp_type        out_beat
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   rsp_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   // room for a full pair of tokens
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_beat  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entries_ff[wr_next] <= push.second;
   end

endmodule

`default_nettype wire

@@ hw/rtl/stl_checker.sv @@
// Port-level checks on the lexer top level, bound into every instance.
`default_nettype none

module stl_checker
   import stl_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_beat,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_beat
);

   // a stalled source beat stays offered with the same payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_beat))
      else $error("req beat dropped or changed while stalled");

   // a stalled token stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled token holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_beat))
      else $error("rsp beat changed while stalled");

   // input backpressure only comes from queued tokens
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no token queued");

   // reset leaves an empty queue that accepts input
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

endmodule

bind source_token_lexer_unit stl_checker u_stl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_beat  (req_beat),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_beat  (rsp_beat)
);

`default_nettype wire
